// File: sv/sri_pkg.sv
// shared types and constants for the s-random interleaver builder
package sri_pkg;

  // field widths fixed by the item format
  localparam int POS_W     = 13;
  localparam int SPREAD_W  = 6;
  localparam int LENGTH_W  = 14;
  localparam int VERDICT_W = 2;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = LENGTH_W;

  // register reset values
  localparam logic [SPREAD_W-1:0] SPREAD_RESET = 6'd16;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET = 14'd8192;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SPREAD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH = 1'b1;

  // result verdict codes
  typedef enum logic [VERDICT_W-1:0] {
    VERDICT_REJECT   = 2'd0,
    VERDICT_ACCEPT   = 2'd1,
    VERDICT_DEAD_END = 2'd2
  } verdict_t;

  // control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PROBE,
    ST_EVAL,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

// File: sv/s_random_interleaver_builder.sv
// top level of the s-random interleaver builder
// Each candidate item yields one result item. A candidate is settled in steps:
// probe, used-map read and spread compare in the cell row, decision, output
// load. When it breaks the spread, the block walks the free positions from
// zero, one per cycle through the used-map ram and the cell row, and stops at
// the first one that fits. The used map is cleared by a sweep, one entry a
// cycle, after reset, after each pass end and when a pass is abandoned because
// length_in_use was lowered to or below the current index; no item is taken
// during the sweep, configuration writes are always taken.
module s_random_interleaver_builder
  import sri_pkg::*;
#(
  parameter int MAX_LENGTH = 8192,
  parameter int MAX_SPREAD = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // candidate items
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [POS_W-1:0]      in_candidate,
  // result items
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [POS_W-1:0]      out_entry_index,
  output logic [POS_W-1:0]      out_entry_position,
  output logic [VERDICT_W-1:0]  out_verdict,
  output logic                  out_pass_end,
  output logic                  out_pass_ok,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = $clog2(MAX_LENGTH);
  localparam int LW = $clog2(MAX_LENGTH + 1);
  localparam int SW = $clog2(MAX_SPREAD + 1);
  localparam int NC = MAX_SPREAD - 1;
  localparam int EW = (LW > LENGTH_W) ? LW : LENGTH_W;
  localparam int XW = (SW > SPREAD_W) ? SW : SPREAD_W;
  localparam int MW = (LW > SW) ? LW : SW;

  // configuration registers
  logic [SPREAD_W-1:0] spread_r;
  logic [LENGTH_W-1:0] length_r;

  // control state
  state_t         state_r, state_nxt;
  logic [AW-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic           pend_r, pend_nxt;
  logic [POS_W-1:0] cand_r, cand_nxt;
  logic [LW-1:0]  fill_idx_r, fill_idx_nxt;
  logic           failed_r, failed_nxt;
  logic [LW-1:0]  scan_k_r, scan_k_nxt;
  logic           s1_vld_r, s1_vld_nxt;
  logic           s1_last_r, s1_last_nxt;
  verdict_t       verdict_r, verdict_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [POS_W-1:0] out_index_r, out_index_nxt;
  logic [POS_W-1:0] out_pos_r, out_pos_nxt;
  verdict_t         out_verdict_r, out_verdict_nxt;
  logic             out_pend_r, out_pend_nxt;
  logic             out_pok_r, out_pok_nxt;

  // datapath signals
  logic [SW-1:0]  s_eff;
  logic [LW-1:0]  len_eff;
  logic [SW-1:0]  n_active;
  logic [AW-1:0]  probe;
  logic           cand_ok;
  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic           ram_wdata;
  logic           ram_rdata;
  logic           shift_en;
  logic           viol_any;
  logic [NC-1:0]  viol_vec;
  logic [AW-1:0]  chain_pos [NC+1];
  logic [LW-1:0]  fill_inc;

  // saturate the registers to their usable ranges
  always_comb begin
    if (XW'(spread_r) < XW'(1)) begin
      s_eff = SW'(1);
    end else if (XW'(spread_r) > XW'(MAX_SPREAD)) begin
      s_eff = SW'(MAX_SPREAD);
    end else begin
      s_eff = SW'(spread_r);
    end
    if (EW'(length_r) < EW'(2)) begin
      len_eff = LW'(2);
    end else if (EW'(length_r) > EW'(MAX_LENGTH)) begin
      len_eff = LW'(MAX_LENGTH);
    end else begin
      len_eff = LW'(length_r);
    end
  end

  // number of earlier entries checked against the spread
  assign n_active = (MW'(fill_idx_r) < MW'(s_eff - SW'(1))) ? SW'(fill_idx_r)
                                                            : (s_eff - SW'(1));
  assign cand_ok  = EW'(cand_r) < EW'(len_eff);
  assign probe    = (state_r == ST_SCAN) ? scan_k_r[AW-1:0] : AW'(cand_r);
  assign viol_any = |viol_vec;
  assign fill_inc = fill_idx_r + LW'(1);

  // configuration port, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spread_r <= SPREAD_RESET;
      length_r <= LENGTH_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SPREAD) begin
        spread_r <= cfg_data[SPREAD_W-1:0];
      end else if (cfg_index == CFG_LENGTH) begin
        length_r <= cfg_data;
      end
    end
  end

  // used-position map
  sri_ram #(
    .WIDTH (1),
    .DEPTH (MAX_LENGTH)
  ) u_used_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (probe),
    .rdata (ram_rdata)
  );

  // row of recent-position cells, most recent first
  assign chain_pos[0] = AW'(cand_r);

  for (genvar g = 0; g < NC; g++) begin : g_cell
    sri_cell #(
      .AW  (AW),
      .SW  (SW),
      .IDX (g)
    ) u_cell (
      .clk      (clk),
      .shift_en (shift_en),
      .pos_in   (chain_pos[g]),
      .probe    (probe),
      .spread   (s_eff),
      .n_active (n_active),
      .pos_out  (chain_pos[g+1]),
      .viol     (viol_vec[g])
    );
  end

  // sequencer: next state and outputs
  always_comb begin
    state_nxt       = state_r;
    clr_cnt_nxt     = clr_cnt_r;
    pend_nxt        = pend_r;
    cand_nxt        = cand_r;
    fill_idx_nxt    = fill_idx_r;
    failed_nxt      = failed_r;
    scan_k_nxt      = scan_k_r;
    s1_vld_nxt      = 1'b0;
    s1_last_nxt     = 1'b0;
    verdict_nxt     = verdict_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_index_nxt   = out_index_r;
    out_pos_nxt     = out_pos_r;
    out_verdict_nxt = out_verdict_r;
    out_pend_nxt    = out_pend_r;
    out_pok_nxt     = out_pok_r;
    ram_we          = 1'b0;
    ram_waddr       = clr_cnt_r;
    ram_wdata       = 1'b0;
    shift_en        = 1'b0;
    in_ready        = 1'b0;

    unique case (state_r)
      // sweep the used map, one entry a cycle
      ST_CLEAR: begin
        ram_we = 1'b1;
        if (clr_cnt_r == AW'(MAX_LENGTH - 1)) begin
          pend_nxt  = 1'b0;
          state_nxt = pend_r ? ST_PROBE : ST_IDLE;
        end else begin
          clr_cnt_nxt = clr_cnt_r + AW'(1);
        end
      end
      // take a candidate; abandon the pass if the length dropped to or below it
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cand_nxt = in_candidate;
          if (fill_idx_r >= len_eff) begin
            pend_nxt     = 1'b1;
            clr_cnt_nxt  = '0;
            fill_idx_nxt = '0;
            failed_nxt   = 1'b0;
            state_nxt    = ST_CLEAR;
          end else begin
            state_nxt = ST_PROBE;
          end
        end
      end
      // candidate goes to the map and the cells
      ST_PROBE: begin
        if (cand_ok) begin
          state_nxt = ST_EVAL;
        end else begin
          verdict_nxt = VERDICT_REJECT;
          state_nxt   = ST_DONE;
        end
      end
      // used or fitting decides at once, a spread miss starts the scan
      ST_EVAL: begin
        if (ram_rdata) begin
          verdict_nxt = VERDICT_REJECT;
          state_nxt   = ST_DONE;
        end else if (!viol_any) begin
          verdict_nxt = VERDICT_ACCEPT;
          state_nxt   = ST_DONE;
        end else begin
          scan_k_nxt = '0;
          state_nxt  = ST_SCAN;
        end
      end
      // walk the free positions, one issued and one judged each cycle
      ST_SCAN: begin
        if (scan_k_r < len_eff) begin
          s1_vld_nxt  = 1'b1;
          s1_last_nxt = scan_k_r == (len_eff - LW'(1));
          scan_k_nxt  = scan_k_r + LW'(1);
        end
        if (s1_vld_r && !ram_rdata && !viol_any) begin
          verdict_nxt = VERDICT_REJECT;
          state_nxt   = ST_DONE;
        end else if (s1_vld_r && s1_last_r) begin
          verdict_nxt = VERDICT_DEAD_END;
          state_nxt   = ST_DONE;
        end
      end
      // load the result, and commit a non-rejected entry, when the output slot is free
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_index_nxt   = POS_W'(fill_idx_r);
          out_verdict_nxt = verdict_r;
          out_pos_nxt     = (verdict_r != VERDICT_REJECT) ? cand_r : '0;
          out_pend_nxt    = 1'b0;
          out_pok_nxt     = 1'b0;
          state_nxt       = ST_IDLE;
          if (verdict_r != VERDICT_REJECT) begin
            ram_we       = 1'b1;
            ram_waddr    = AW'(cand_r);
            ram_wdata    = 1'b1;
            shift_en     = 1'b1;
            fill_idx_nxt = fill_inc;
            failed_nxt   = failed_r || (verdict_r == VERDICT_DEAD_END);
            if (fill_inc >= len_eff) begin
              out_pend_nxt = 1'b1;
              out_pok_nxt  = !(failed_r || (verdict_r == VERDICT_DEAD_END));
              clr_cnt_nxt  = '0;
              fill_idx_nxt = '0;
              failed_nxt   = 1'b0;
              state_nxt    = ST_CLEAR;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      pend_r      <= 1'b0;
      fill_idx_r  <= '0;
      failed_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      s1_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pend_r      <= pend_nxt;
      fill_idx_r  <= fill_idx_nxt;
      failed_r    <= failed_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s1_last_r   <= s1_last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cand_r        <= cand_nxt;
    scan_k_r      <= scan_k_nxt;
    verdict_r     <= verdict_nxt;
    out_index_r   <= out_index_nxt;
    out_pos_r     <= out_pos_nxt;
    out_verdict_r <= out_verdict_nxt;
    out_pend_r    <= out_pend_nxt;
    out_pok_r     <= out_pok_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_entry_index    = out_index_r;
  assign out_entry_position = out_pos_r;
  assign out_verdict        = out_verdict_r;
  assign out_pass_end       = out_pend_r;
  assign out_pass_ok        = out_pok_r;

endmodule

// File: sv/sri_ram.sv
// generic single write port ram with registered read
module sri_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: sv/sri_cell.sv
// one cell of the recent-position chain: holds a position and checks spread
module sri_cell #(
  parameter int AW  = 13,
  parameter int SW  = 6,
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          shift_en,
  input  logic [AW-1:0] pos_in,
  input  logic [AW-1:0] probe,
  input  logic [SW-1:0] spread,
  input  logic [SW-1:0] n_active,
  output logic [AW-1:0] pos_out,
  output logic          viol
);

  localparam int CW = (AW > SW) ? AW : SW;

  logic [AW-1:0] pos_r;
  logic          viol_r;
  logic [AW-1:0] pos_gap;
  logic          active;
  logic          viol_nxt;

  // distance from the probe to the held position
  always_comb begin
    pos_gap  = (probe > pos_r) ? (probe - pos_r) : (pos_r - probe);
    active   = SW'(IDX) < n_active;
    viol_nxt = active && (CW'(pos_gap) < CW'(spread));
  end

  // held position moves one cell down on each committed (non-rejected) entry
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pos_r <= pos_in;
    end
    viol_r <= viol_nxt;
  end

  assign pos_out = pos_r;
  assign viol    = viol_r;

endmodule

// File: sv/sri_chk.sv
// port-level checks for the s-random interleaver builder, bound to the top
module sri_chk
  import sri_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [POS_W-1:0]      out_entry_index,
  input logic [POS_W-1:0]      out_entry_position,
  input logic [VERDICT_W-1:0]  out_verdict,
  input logic                  out_pass_end,
  input logic                  out_pass_ok
);

  // only the three verdict codes ever leave the block
  a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_verdict == VERDICT_REJECT || out_verdict == VERDICT_ACCEPT ||
                   out_verdict == VERDICT_DEAD_END))
    else $error("verdict code out of range");

  // a rejected item carries no position and never ends a pass
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_verdict == VERDICT_REJECT) |->
      (out_entry_position == '0 && !out_pass_end && !out_pass_ok))
    else $error("rejected item carries acceptance data");

  // pass ok is only reported at a pass end, never after a dead end
  a_pass_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_pass_ok) |-> (out_pass_end && out_verdict == VERDICT_ACCEPT))
    else $error("pass ok without a clean pass end");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_entry_index) && $stable(out_entry_position) &&
       $stable(out_verdict) && $stable(out_pass_end) && $stable(out_pass_ok)))
    else $error("stalled result changed");

endmodule

bind s_random_interleaver_builder sri_chk u_sri_chk (.*);
